// File: design/vdc_pkg.sv
// Shared types and widths for the Verlet stick distance constraint.
// No dependencies; every design module imports this package.
package vdc_pkg;

  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 33;

  typedef logic signed [31:0] coord_t;

  // Two points that travel along a cell chain next to the arithmetic.
  typedef struct packed {
    coord_t p_x;
    coord_t p_y;
    coord_t q_x;
    coord_t q_y;
    logic   move_a;
    logic   degen;
  } side_t;

  // Square root state: radicand still to consume, partial remainder and root.
  typedef struct packed {
    logic [65:0] rad;
    logic [35:0] rem;
    logic [32:0] root;
  } sq_t;

  // Division state for the x and y lanes, which share one divisor.
  typedef struct packed {
    logic [32:0]      h;
    logic [1:0]       neg;
    logic [1:0][32:0] rem;
    logic [1:0][32:0] dq;
  } dv_t;

  typedef struct packed {
    coord_t      moved_x;
    coord_t      moved_y;
    logic        moved_is_a;
    logic [31:0] new_length;
    logic        degenerate;
  } res_t;

endpackage

// File: design/vdc_in_if.sv
// Input channel: one stick (two endpoints and the direction flag) per beat.
// No dependencies.
interface vdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic               move_a;

  modport source (output valid, a_x, a_y, b_x, b_y, move_a, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, move_a, output ready);
endinterface

// File: design/vdc_out_if.sv
// Result channel: the moved point and the new stick length per beat.
// No dependencies.
interface vdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] moved_x;
  logic signed [31:0] moved_y;
  logic               moved_is_a;
  logic [31:0]        new_length;
  logic               degenerate;

  modport source (output valid, moved_x, moved_y, moved_is_a, new_length, degenerate,
                  input ready);
  modport sink (input valid, moved_x, moved_y, moved_is_a, new_length, degenerate,
                output ready);
endinterface

// File: design/vdc_cfg_if.sv
// Configuration write channel carrying the rest length.
// No dependencies.
interface vdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] rest_length;

  modport source (output valid, rest_length, input ready);
  modport sink (input valid, rest_length, output ready);
endinterface

// File: design/verlet_distance_constraint.sv
// Verlet stick distance constraint: moves one endpoint of a stick so that the
// stick regains its rest length, and reports the new length.
// Depends on vdc_pkg, the three channel interfaces, vdc_sqrt_chain, vdc_div_cell.
//
// Usage:
//   in_ch carries one stick per beat (A, B, move_a); out_ch returns one result
//   per stick in the same order. cfg_ch writes rest_length and is always ready;
//   write it only while no stick is in flight.
//   The block is a chain of cells: a 33-cell square root, a 33-cell divider
//   (x and y lanes side by side) and a second 33-cell square root for the new
//   length, with registered stages for differences, squares, products and
//   the move with saturation. The path holds 107 register stages.
//   Throughput is one stick per cycle while out_ch accepts results; each cell
//   handles one root or quotient bit.
//   Reset clears all valid bits and sets rest_length to 0.
//   When out_ch stalls, a one-entry skid buffer catches the result in flight
//   and the whole chain holds; in_ch.ready then drops until the skid drains.
module verlet_distance_constraint (
  input logic          clk,
  input logic          rst_n,
  vdc_in_if.sink       in_ch,
  vdc_out_if.source    out_ch,
  vdc_cfg_if.sink      cfg_ch
);
  import vdc_pkg::*;

  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic signed [32:0] n;
    begin
      n = -d;
      return d[32] ? n[31:0] : d[31:0];
    end
  endfunction

  function automatic coord_t sat32(input logic signed [34:0] v);
    begin
      if (v > 35'sd2147483647) begin
        return 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
        return 32'sh80000000;
      end else begin
        return v[31:0];
      end
    end
  endfunction

  logic [30:0] rest_r;
  logic        en;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= '0;
    end else if (cfg_ch.valid) begin
      rest_r <= cfg_ch.rest_length;
    end
  end

  // Stage 1: register the stick and the absolute coordinate differences.
  logic        s1_v_r;
  side_t       s1_side_r;
  logic [31:0] s1_mx_r, s1_my_r;
  side_t       in_side;

  always_comb begin
    in_side.p_x    = in_ch.a_x;
    in_side.p_y    = in_ch.a_y;
    in_side.q_x    = in_ch.b_x;
    in_side.q_y    = in_ch.b_y;
    in_side.move_a = in_ch.move_a;
    in_side.degen  = 1'b0;
  end

  assign in_ch.ready = en;

  // Stage 2: squares.
  logic        s2_v_r;
  side_t       s2_side_r;
  logic [63:0] s2_sx_r, s2_sy_r;

  // First square root: h.
  logic        c1_v;
  logic [32:0] c1_root;
  side_t       c1_side;

  // Stage 4: error and direction magnitudes.
  logic               s4_v_r;
  side_t              s4_side_r;
  logic [32:0]        s4_absdiff_r;
  logic [31:0]        s4_mx_r, s4_my_r;
  logic [1:0]         s4_neg_r;
  logic [32:0]        s4_h_r;
  logic signed [33:0] diff;
  logic signed [32:0] c1_dx, c1_dy;
  logic signed [33:0] ndiff;
  side_t              c1_side_dg;

  // Stage 5: products.
  logic        s5_v_r;
  side_t       s5_side_r;
  logic [64:0] s5_px_r, s5_py_r;
  logic [1:0]  s5_neg_r;
  logic [32:0] s5_h_r;

  // Divider chain.
  logic  dv_v  [0:DivSteps];
  dv_t   dv    [0:DivSteps];
  side_t dv_sd [0:DivSteps];

  // Stage 6: move and saturate.
  logic               s6_v_r;
  side_t              s6_side_r;
  side_t              s6_nxt;
  logic signed [34:0] off_x, off_y, sum_x, sum_y;
  dv_t                dv_end;
  side_t              sd_end;

  // Stage 7 and 8: distance of the new stick.
  logic        s7_v_r;
  side_t       s7_side_r;
  logic [31:0] s7_mx_r, s7_my_r;
  logic        s8_v_r;
  side_t       s8_side_r;
  logic [63:0] s8_sx_r, s8_sy_r;

  logic        c2_v;
  logic [32:0] c2_root;
  side_t       c2_side;

  // Output register and skid buffer.
  logic  out_v_r, sk_v_r;
  res_t  out_d_r, sk_d_r, inc_d;
  logic  inc_v;

  assign en = !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s4_v_r <= c1_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= dv_v[DivSteps];
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_comb begin
    diff  = $signed({3'b000, rest_r}) - $signed({1'b0, c1_root});
    ndiff = -diff;
    c1_dx = $signed({c1_side.q_x[31], c1_side.q_x}) - $signed({c1_side.p_x[31], c1_side.p_x});
    c1_dy = $signed({c1_side.q_y[31], c1_side.q_y}) - $signed({c1_side.p_y[31], c1_side.p_y});
    c1_side_dg       = c1_side;
    c1_side_dg.degen = (c1_root == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= in_side;
      s1_mx_r   <= mag33($signed({in_ch.b_x[31], in_ch.b_x}) -
                         $signed({in_ch.a_x[31], in_ch.a_x}));
      s1_my_r   <= mag33($signed({in_ch.b_y[31], in_ch.b_y}) -
                         $signed({in_ch.a_y[31], in_ch.a_y}));

      s2_side_r <= s1_side_r;
      s2_sx_r   <= 64'(s1_mx_r) * 64'(s1_mx_r);
      s2_sy_r   <= 64'(s1_my_r) * 64'(s1_my_r);

      s4_side_r       <= c1_side_dg;
      s4_absdiff_r    <= diff[33] ? ndiff[32:0] : diff[32:0];
      s4_mx_r         <= mag33(c1_dx);
      s4_my_r         <= mag33(c1_dy);
      s4_neg_r        <= {diff[33] ^ c1_dy[32], diff[33] ^ c1_dx[32]};
      s4_h_r          <= c1_root;

      s5_side_r <= s4_side_r;
      s5_px_r   <= 65'(s4_absdiff_r) * 65'(s4_mx_r);
      s5_py_r   <= 65'(s4_absdiff_r) * 65'(s4_my_r);
      s5_neg_r  <= s4_neg_r;
      s5_h_r    <= s4_h_r;

      s6_side_r <= s6_nxt;

      s7_side_r <= s6_side_r;
      s7_mx_r   <= mag33($signed({s6_side_r.q_x[31], s6_side_r.q_x}) -
                         $signed({s6_side_r.p_x[31], s6_side_r.p_x}));
      s7_my_r   <= mag33($signed({s6_side_r.q_y[31], s6_side_r.q_y}) -
                         $signed({s6_side_r.p_y[31], s6_side_r.p_y}));

      s8_side_r <= s7_side_r;
      s8_sx_r   <= 64'(s7_mx_r) * 64'(s7_mx_r);
      s8_sy_r   <= 64'(s7_my_r) * 64'(s7_my_r);
    end
  end

  vdc_sqrt_chain u_sqrt_h (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (s2_v_r),
    .rad_i  (66'(s2_sx_r) + 66'(s2_sy_r)),
    .side_i (s2_side_r),
    .v_o    (c1_v),
    .root_o (c1_root),
    .side_o (c1_side)
  );

  // The high half of each product is below h, so it seeds the remainder.
  always_comb begin
    dv_v[0]       = s5_v_r;
    dv_sd[0]      = s5_side_r;
    dv[0].h       = s5_h_r;
    dv[0].neg     = s5_neg_r;
    dv[0].rem[0]  = {1'b0, s5_px_r[64:33]};
    dv[0].rem[1]  = {1'b0, s5_py_r[64:33]};
    dv[0].dq[0]   = s5_px_r[32:0];
    dv[0].dq[1]   = s5_py_r[32:0];
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    vdc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[i]),
      .dv_i   (dv[i]),
      .side_i (dv_sd[i]),
      .v_r    (dv_v[i+1]),
      .dv_r   (dv[i+1]),
      .side_r (dv_sd[i+1])
    );
  end

  // After the move, p holds the moved point and q the fixed one.
  always_comb begin
    dv_end = dv[DivSteps];
    sd_end = dv_sd[DivSteps];
    off_x  = dv_end.neg[0] ? -$signed({2'b00, dv_end.dq[0]}) : $signed({2'b00, dv_end.dq[0]});
    off_y  = dv_end.neg[1] ? -$signed({2'b00, dv_end.dq[1]}) : $signed({2'b00, dv_end.dq[1]});
    s6_nxt = sd_end;
    if (sd_end.move_a) begin
      sum_x      = $signed({{3{sd_end.p_x[31]}}, sd_end.p_x}) - off_x;
      sum_y      = $signed({{3{sd_end.p_y[31]}}, sd_end.p_y}) - off_y;
      s6_nxt.q_x = sd_end.q_x;
      s6_nxt.q_y = sd_end.q_y;
      s6_nxt.p_x = sd_end.degen ? sd_end.p_x : sat32(sum_x);
      s6_nxt.p_y = sd_end.degen ? sd_end.p_y : sat32(sum_y);
    end else begin
      sum_x      = $signed({{3{sd_end.q_x[31]}}, sd_end.q_x}) + off_x;
      sum_y      = $signed({{3{sd_end.q_y[31]}}, sd_end.q_y}) + off_y;
      s6_nxt.q_x = sd_end.p_x;
      s6_nxt.q_y = sd_end.p_y;
      s6_nxt.p_x = sd_end.degen ? sd_end.q_x : sat32(sum_x);
      s6_nxt.p_y = sd_end.degen ? sd_end.q_y : sat32(sum_y);
    end
  end

  vdc_sqrt_chain u_sqrt_len (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (s8_v_r),
    .rad_i  (66'(s8_sx_r) + 66'(s8_sy_r)),
    .side_i (s8_side_r),
    .v_o    (c2_v),
    .root_o (c2_root),
    .side_o (c2_side)
  );

  always_comb begin
    inc_v              = c2_v && en;
    inc_d.moved_x      = c2_side.p_x;
    inc_d.moved_y      = c2_side.p_y;
    inc_d.moved_is_a   = c2_side.move_a;
    inc_d.degenerate   = c2_side.degen;
    if (c2_side.degen) begin
      inc_d.new_length = '0;
    end else if (c2_root[32]) begin
      inc_d.new_length = '1;
    end else begin
      inc_d.new_length = c2_root[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= inc_v;
      end
    end else if (inc_v) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_d_r <= sk_v_r ? sk_d_r : inc_d;
    end else if (inc_v) begin
      sk_d_r <= inc_d;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.moved_x    = out_d_r.moved_x;
  assign out_ch.moved_y    = out_d_r.moved_y;
  assign out_ch.moved_is_a = out_d_r.moved_is_a;
  assign out_ch.new_length = out_d_r.new_length;
  assign out_ch.degenerate = out_d_r.degenerate;
endmodule

// File: design/vdc_sqrt_cell.sv
// One step of a restoring square root: consumes two radicand bits per beat.
// Depends on vdc_pkg.
module vdc_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  vdc_pkg::sq_t   sq_i,
  input  vdc_pkg::side_t side_i,
  output logic           v_r,
  output vdc_pkg::sq_t   sq_r,
  output vdc_pkg::side_t side_r
);
  import vdc_pkg::*;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;
  sq_t         sq_nxt;

  always_comb begin
    rem_sh      = {sq_i.rem[33:0], sq_i.rad[65:64]};
    trial       = {1'b0, sq_i.root, 2'b01};
    take        = (rem_sh >= trial);
    sq_nxt.rad  = {sq_i.rad[63:0], 2'b00};
    sq_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    sq_nxt.root = {sq_i.root[31:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_i;
    end
  end
endmodule

// File: design/vdc_div_cell.sv
// One step of restoring division for both lanes: one quotient bit per beat.
// Depends on vdc_pkg.
module vdc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  vdc_pkg::dv_t   dv_i,
  input  vdc_pkg::side_t side_i,
  output logic           v_r,
  output vdc_pkg::dv_t   dv_r,
  output vdc_pkg::side_t side_r
);
  import vdc_pkg::*;

  logic [33:0] r2;
  logic [33:0] dvsr;
  logic        take;
  dv_t         dv_nxt;

  always_comb begin
    dv_nxt = dv_i;
    dvsr   = {1'b0, dv_i.h};
    r2     = '0;
    take   = 1'b0;
    for (int k = 0; k < 2; k++) begin
      r2             = {dv_i.rem[k], dv_i.dq[k][32]};
      take           = (r2 >= dvsr);
      dv_nxt.rem[k]  = take ? 33'(r2 - dvsr) : r2[32:0];
      dv_nxt.dq[k]   = {dv_i.dq[k][31:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r   <= dv_nxt;
      side_r <= side_i;
    end
  end
endmodule

// File: design/vdc_sqrt_chain.sv
// Row of square root cells giving floor(sqrt) of a 66-bit radicand.
// Depends on vdc_pkg and vdc_sqrt_cell.
module vdc_sqrt_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  logic [65:0]    rad_i,
  input  vdc_pkg::side_t side_i,
  output logic           v_o,
  output logic [32:0]    root_o,
  output vdc_pkg::side_t side_o
);
  import vdc_pkg::*;

  logic  v  [0:SqrtSteps];
  sq_t   sq [0:SqrtSteps];
  side_t sd [0:SqrtSteps];

  assign v[0]  = v_i;
  assign sq[0] = {rad_i, 36'd0, 33'd0};
  assign sd[0] = side_i;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_cell
    vdc_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (v[i]),
      .sq_i   (sq[i]),
      .side_i (sd[i]),
      .v_r    (v[i+1]),
      .sq_r   (sq[i+1]),
      .side_r (sd[i+1])
    );
  end

  assign v_o    = v[SqrtSteps];
  assign root_o = sq[SqrtSteps].root;
  assign side_o = sd[SqrtSteps];
endmodule

// File: sim/vdc_tb_checker.sv
// Scoreboard for the stick distance constraint: watches the config, input and
// result channels, predicts each result and compares. Depends on vdc_pkg.
module vdc_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  vdc_in_if           in_ch,
  vdc_out_if          out_ch,
  vdc_cfg_if          cfg_ch,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vdc_pkg::*;

  logic [30:0] rest_len;
  res_t        expected_q[$];

  function automatic logic [32:0] isqrt66(logic [65:0] v);
    logic [32:0] root;
    logic [67:0] rem;
    logic [67:0] trial;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 33'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [32:0] stick_len(longint ax, longint ay, longint bx, longint by);
    longint      dx;
    longint      dy;
    logic [65:0] sq;
    dx = bx - ax;
    dy = by - ay;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
    return isqrt66(sq);
  endfunction

  // diff * delta / h, truncated toward zero
  function automatic longint shift_along(longint diff, longint delta, longint h);
    logic [127:0] prod;
    logic [127:0] q;
    longint       md;
    longint       mt;
    md = diff < 0 ? -diff : diff;
    mt = delta < 0 ? -delta : delta;
    prod = 128'(md) * 128'(mt);
    q = prod / 128'(h);
    return ((diff < 0) != (delta < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic res_t relax_stick(coord_t ax_i, coord_t ay_i, coord_t bx_i,
                                       coord_t by_i, logic ma);
    res_t   r;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint h;
    longint diff;
    longint ox;
    longint oy;
    longint mx;
    longint my;
    longint len;
    ax = ax_i; ay = ay_i; bx = bx_i; by = by_i;
    h = longint'(stick_len(ax, ay, bx, by));
    r.moved_is_a = ma;
    r.degenerate = (h == 0);
    if (h == 0) begin
      mx = ma ? ax : bx;
      my = ma ? ay : by;
      len = 0;
    end else begin
      diff = longint'(rest_len) - h;
      ox = shift_along(diff, bx - ax, h);
      oy = shift_along(diff, by - ay, h);
      if (ma) begin
        mx = clamp32(ax - ox);
        my = clamp32(ay - oy);
        len = longint'(stick_len(mx, my, bx, by));
      end else begin
        mx = clamp32(bx + ox);
        my = clamp32(by + oy);
        len = longint'(stick_len(ax, ay, mx, my));
      end
      if (len > 64'sd4294967295) len = 64'sd4294967295;
    end
    r.moved_x = mx[31:0];
    r.moved_y = my[31:0];
    r.new_length = len[31:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      rest_len <= '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h %h", $time,
                   out_ch.moved_x, out_ch.moved_y);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.moved_x !== e.moved_x || out_ch.moved_y !== e.moved_y ||
              out_ch.moved_is_a !== e.moved_is_a || out_ch.new_length !== e.new_length ||
              out_ch.degenerate !== e.degenerate) begin
            $display("%0t: expected x=%h y=%h a=%b len=%h deg=%b, got x=%h y=%h a=%b len=%h deg=%b",
                     $time, e.moved_x, e.moved_y, e.moved_is_a, e.new_length, e.degenerate,
                     out_ch.moved_x, out_ch.moved_y, out_ch.moved_is_a, out_ch.new_length,
                     out_ch.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(relax_stick(in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y,
                                         in_ch.move_a));
      if (cfg_ch.valid && cfg_ch.ready) rest_len <= cfg_ch.rest_length;
    end
  end
endmodule

// File: sim/tb_top.sv
// Top of the stick distance constraint testbench: clock, reset, stimulus and
// verdict. Depends on the channel interfaces, the DUT and vdc_tb_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_recv = 1'b0;

  vdc_in_if  in_ch ();
  vdc_out_if out_ch ();
  vdc_cfg_if cfg_ch ();

  verlet_distance_constraint DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  vdc_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("verlet_distance_constraint: mismatch");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      default: return 32'($signed($urandom_range(40000)) - 20000) <<< $urandom_range(16);
    endcase
  endfunction

  task automatic send_stick(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                            logic [31:0] by, logic ma);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= ax;
    in_ch.a_y <= ay;
    in_ch.b_x <= bx;
    in_ch.b_y <= by;
    in_ch.move_a <= ma;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random();
    logic [31:0] ax;
    logic [31:0] ay;
    ax = rand_coord();
    ay = rand_coord();
    // Mostly nearby endpoints, sometimes anywhere, now and then coincident.
    case ($urandom_range(9))
      0: send_stick(ax, ay, ax, ay, 1'($urandom()));
      1, 2: send_stick(ax, ay, rand_coord(), rand_coord(), 1'($urandom()));
      default: send_stick(ax, ay, ax + 32'($signed($urandom_range(2000000)) - 1000000),
                          ay + 32'($signed($urandom_range(2000000)) - 1000000),
                          1'($urandom()));
    endcase
  endtask

  // Waits until the block is empty, then writes the rest length.
  task automatic set_rest(logic [30:0] v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.rest_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.move_a = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.rest_length = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sticks at the default rest length of zero, then at the largest.
    for (int pass = 0; pass < 2; pass++) begin
      send_stick(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_stick(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 32'hffff_0000, 1'b1);
      send_stick(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1'b0);
      send_stick(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1'b1);
      send_stick(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      send_stick(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      send_stick(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_stick(32'h0, 32'h0, 32'h0, 32'h1, 1'b1);
      send_stick(32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1'b0);
      send_stick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      if (pass == 0) set_rest(31'h7fff_ffff);
    end

    set_rest(31'h0005_0000);
    send_idle_pct = 16;
    recv_idle_pct = 85;
    repeat (250) send_random();

    // Receiver holds off long enough for the chain and the input to stall.
    hold_recv = 1'b1;
    fork
      repeat (300) @(posedge clk);
      repeat (150) send_random();
    join_any
    hold_recv = 1'b0;
    wait fork;

    set_rest(31'($urandom()));
    send_idle_pct = 85;
    recv_idle_pct = 16;
    repeat (200) send_random();

    set_rest(31'h0000_0001);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) send_random();
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("verlet_distance_constraint: match");
    end else begin
      $display("verlet_distance_constraint: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
design/vdc_pkg.sv
design/vdc_in_if.sv
design/vdc_out_if.sv
design/vdc_cfg_if.sv
design/vdc_sqrt_cell.sv
design/vdc_div_cell.sv
design/vdc_sqrt_chain.sv
design/verlet_distance_constraint.sv
sim/vdc_tb_checker.sv
sim/tb_top.sv
